@@ src/ssr_pkg.sv @@
package ssr_pkg;

  localparam int BYTE_W = 8;
  localparam int WIN    = 8;
  localparam int CNT_W  = 4;
  localparam int IDX_W  = $clog2(WIN);
  localparam int QDEPTH = 2;
  localparam int CFG_W  = 64;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_PATTERN_LEN_DEF = 8;
  localparam int MAX_REPLACE_LEN_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN   = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_present;
    logic              run_end;
    logic              text_end;
  } out_item_t;

  // one input's worth of output beats
  typedef struct packed {
    logic [WIN-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]           count;
    logic                       present;
    logic                       last;
  } job_t;

endpackage

@@ src/ssr_front.sv @@
module ssr_front #(
  parameter int MAX_PATTERN_LEN = ssr_pkg::MAX_PATTERN_LEN_DEF,
  parameter int MAX_REPLACE_LEN = ssr_pkg::MAX_REPLACE_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  ssr_pkg::in_item_t                 in_data,
  output logic                              in_stall,
  input  logic                              cfg_valid,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssr_pkg::CFG_W-1:0]         cfg_data,
  output logic                              cfg_ready,
  input  logic                              q_full,
  output logic                              q_push,
  output ssr_pkg::job_t                     q_job
);
  import ssr_pkg::*;

  localparam int PLIM = (MAX_PATTERN_LEN > WIN) ? WIN : MAX_PATTERN_LEN;
  localparam int RLIM = (MAX_REPLACE_LEN > WIN) ? WIN : MAX_REPLACE_LEN;

  logic [WIN-1:0][BYTE_W-1:0] pat_r;
  logic [WIN-1:0][BYTE_W-1:0] rep_r;
  logic [CNT_W-1:0]           plen_reg_r;
  logic [CNT_W-1:0]           rlen_reg_r;
  logic [BYTE_W-1:0]          held_r [WIN];
  logic [BYTE_W-1:0]          held_nxt [WIN];
  logic [CNT_W-1:0]           held_cnt_r;
  logic [CNT_W-1:0]           held_cnt_nxt;

  logic [CNT_W-1:0]  plen;
  logic [CNT_W-1:0]  rlen;
  logic [CNT_W-1:0]  hc;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  shift;
  logic [CNT_W-1:0]  pos;
  logic [BYTE_W-1:0] win [WIN];
  logic [WIN-1:0]    ok;
  logic              match;
  logic              accept;
  job_t              job;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  always_comb begin
    plen = plen_reg_r;
    if (plen < 4'd1) plen = 4'd1;
    if (plen > CNT_W'(PLIM)) plen = CNT_W'(PLIM);
    rlen = rlen_reg_r;
    if (rlen > CNT_W'(RLIM)) rlen = CNT_W'(RLIM);
  end

  assign hc = (held_cnt_r >= plen) ? '0 : held_cnt_r;
  assign n  = hc + 4'd1;

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      if (CNT_W'(i) < hc) win[i] = held_r[i];
      else if (CNT_W'(i) == hc) win[i] = in_data.in_byte;
      else win[i] = '0;
    end
  end

  // ok[s]: win[s..n-1] is a prefix of the pattern
  always_comb begin
    for (int s = 0; s < WIN; s++) begin
      ok[s] = CNT_W'(s) < n;
      for (int j = 0; j < WIN - s; j++) begin
        if (CNT_W'(s + j) < n && win[s + j] != pat_r[j]) ok[s] = 1'b0;
      end
    end
  end

  always_comb begin
    shift = n;
    for (int s = WIN - 1; s >= 0; s--) begin
      if (ok[s]) shift = CNT_W'(s);
    end
  end

  assign match = (n == plen) && ok[0];

  always_comb begin
    job.present = 1'b1;
    job.last    = in_data.in_last;
    if (match) begin
      job.bytes = rep_r;
      job.count = rlen;
    end else begin
      for (int i = 0; i < WIN; i++) job.bytes[i] = win[i];
      job.count = in_data.in_last ? n : shift;
    end
    if (job.count == '0 && in_data.in_last) begin
      job.bytes   = '0;
      job.count   = 4'd1;
      job.present = 1'b0;
    end
  end

  assign q_job  = job;
  assign q_push = accept && (job.count != '0);

  always_comb begin
    pos = '0;
    for (int i = 0; i < WIN; i++) begin
      pos = shift + CNT_W'(i);
      held_nxt[i] = (pos < CNT_W'(WIN)) ? win[pos[IDX_W-1:0]] : '0;
    end
    held_cnt_nxt = held_cnt_r;
    if (accept) held_cnt_nxt = (match || in_data.in_last) ? '0 : (n - shift);
    if (cfg_valid && (cfg_index == CFG_PAT_BYTES || cfg_index == CFG_PAT_LEN)) begin
      held_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WIN; i++) held_r[i] <= held_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= '0;
      pat_r      <= '0;
      rep_r      <= '0;
      plen_reg_r <= 4'd1;
      rlen_reg_r <= '0;
    end else begin
      held_cnt_r <= held_cnt_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_PAT_BYTES: pat_r      <= cfg_data;
          CFG_PAT_LEN:   plen_reg_r <= cfg_data[CNT_W-1:0];
          CFG_REP_BYTES: rep_r      <= cfg_data;
          CFG_REP_LEN:   rlen_reg_r <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ src/ssr_fifo.sv @@
module ssr_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ssr_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          nonempty,
  output ssr_pkg::job_t head
);
  import ssr_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int LW = $clog2(QDEPTH + 1);

  job_t          mem_r [QDEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [LW-1:0] level_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_nxt;

  assign full     = (level_r == LW'(QDEPTH));
  assign nonempty = (level_r != '0);
  assign head     = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == AW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == AW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop) rd_ptr_r <= rd_ptr_nxt;
      if (push && !pop) level_r <= level_r + 1'b1;
      else if (pop && !push) level_r <= level_r - 1'b1;
    end
  end

endmodule

@@ src/ssr_back.sv @@
module ssr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nonempty,
  input  ssr_pkg::job_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  output ssr_pkg::out_item_t out_data,
  input  logic               out_stall
);
  import ssr_pkg::*;

  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  out_item_t        beat;
  logic             load;
  logic             run_end;

  assign run_end = (CNT_W'(idx_r) == q_head.count - 4'd1);
  assign load    = q_nonempty && (!out_valid_r || !out_stall);
  assign q_pop   = load && run_end;

  always_comb begin
    beat.out_byte     = q_head.bytes[idx_r];
    beat.byte_present = q_head.present;
    beat.run_end      = run_end;
    beat.text_end     = run_end && q_head.last;
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= run_end ? '0 : idx_r + 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/stream_substring_replace.sv @@
// Streaming find-and-replace over a byte stream.
// Input channel in_valid/in_data/in_stall: one text byte per beat, in_last
// on the final byte of a text. Output channel out_valid/out_data/out_stall:
// one output byte per beat; run_end marks the last beat caused by an input
// byte, text_end the last beat of a text. A last byte with nothing to emit
// yields one empty beat (byte_present 0).
// Config port cfg_valid/cfg_index/cfg_data, always ready: 0 pattern bytes,
// 1 pattern length, 2 replacement bytes, 3 replacement length. Writing the
// pattern drops a held partial match. Write only while the block is idle.
// A result beat passes through the job queue and then the output register.
// Throughput: one input beat per cycle while each input yields at most one
// beat and out_stall stays low; an input yielding more than one beat holds the
// output side for each of its beats, and a 2-entry job queue between the
// matcher and the serializer absorbs the difference before in_stall rises.
// A stall on out_stall holds the output beat; the queue fills and then
// in_stall is raised. Reset empties the queue and the held match and loads
// pattern length 1 with a zero pattern byte and an empty replacement.
module stream_substring_replace #(
  parameter int MAX_PATTERN_LEN = ssr_pkg::MAX_PATTERN_LEN_DEF,
  parameter int MAX_REPLACE_LEN = ssr_pkg::MAX_REPLACE_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  ssr_pkg::in_item_t             in_data,
  output logic                          in_stall,
  output logic                          out_valid,
  output ssr_pkg::out_item_t            out_data,
  input  logic                          out_stall,
  input  logic                          cfg_valid,
  input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssr_pkg::CFG_W-1:0]     cfg_data,
  output logic                          cfg_ready
);
  import ssr_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_nonempty;
  job_t q_job;
  job_t q_head;

  ssr_front #(
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN),
    .MAX_REPLACE_LEN(MAX_REPLACE_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  ssr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  ssr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

  a_text_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.text_end |-> out_data.run_end)
    else $error("text_end without run_end");

  a_empty_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_present |-> out_data.text_end)
    else $error("empty beat before end of text");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_nonempty && !q_push)
    else $error("input stalled with empty queue");

endmodule

@@ tb/stream_substring_replace_tb.sv @@
module stream_substring_replace_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssr_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 8;

  class ReplaceTracker;
    logic [63:0] pat_bytes;
    logic [63:0] rep_bytes;
    logic [3:0]  pat_len_reg;
    logic [3:0]  rep_len_reg;
    logic [7:0]  held [8];
    int unsigned held_n;
    out_item_t   expected_beats [$];
    int unsigned mismatches;
    int unsigned bytes_taken;
    int unsigned beats_checked;

    function void clear();
      pat_bytes = '0;
      rep_bytes = '0;
      pat_len_reg = 4'd1;
      rep_len_reg = 4'd0;
      held_n = 0;
      expected_beats.delete();
      mismatches = 0;
      bytes_taken = 0;
      beats_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_PAT_BYTES: begin
          pat_bytes = data;
          held_n = 0;
        end
        CFG_PAT_LEN: begin
          pat_len_reg = data[3:0];
          held_n = 0;
        end
        CFG_REP_BYTES: rep_bytes = data;
        CFG_REP_LEN:   rep_len_reg = data[3:0];
        default: ;
      endcase
    endfunction

    function bit is_pat_prefix(logic [7:0] w [9], int unsigned from, int unsigned len);
      for (int unsigned i = 0; i < len; i++)
        if (w[from + i] !== pat_bytes[8*i +: 8]) return 1'b0;
      return 1'b1;
    endfunction

    function out_item_t beat_of(logic [7:0] b, bit present);
      out_item_t r;
      r = '0;
      r.out_byte = b;
      r.byte_present = present;
      return r;
    endfunction

    function void take_byte(in_item_t item);
      int unsigned plen, rlen, n, s;
      logic [7:0] w [9];
      out_item_t fresh [$];
      plen = (pat_len_reg == 0) ? 1 : ((pat_len_reg > 8) ? 8 : pat_len_reg);
      rlen = (rep_len_reg > 8) ? 8 : rep_len_reg;
      bytes_taken++;
      if (held_n >= plen) held_n = 0;
      for (int unsigned i = 0; i < held_n; i++) w[i] = held[i];
      w[held_n] = item.in_byte;
      n = held_n + 1;
      s = 0;
      if (n == plen && is_pat_prefix(w, 0, n)) begin
        for (int unsigned i = 0; i < rlen; i++)
          fresh.insert(fresh.size(), beat_of(rep_bytes[8*i +: 8], 1'b1));
        s = n;
      end else begin
        // KMP-style fallback: release bytes until the rest is a pattern prefix
        while (s < n && !is_pat_prefix(w, s, n - s)) begin
          fresh.insert(fresh.size(), beat_of(w[s], 1'b1));
          s++;
        end
      end
      held_n = 0;
      for (int unsigned i = s; i < n; i++) begin
        held[held_n] = w[i];
        held_n++;
      end
      if (item.in_last) begin
        for (int unsigned i = 0; i < held_n; i++)
          fresh.insert(fresh.size(), beat_of(held[i], 1'b1));
        held_n = 0;
        if (fresh.size() == 0) fresh.insert(0, beat_of(8'h00, 1'b0));
      end
      if (fresh.size() > 0) begin
        fresh[fresh.size()-1].run_end = 1'b1;
        fresh[fresh.size()-1].text_end = item.in_last;
      end
      foreach (fresh[i]) expected_beats.insert(expected_beats.size(), fresh[i]);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      beats_checked++;
      if (expected_beats.size() == 0) begin
        $error("output beat with nothing pending: out_byte 0x%0h", got.out_byte);
        mismatches++;
        return;
      end
      want = expected_beats.pop_front();
      cmp_field("out_byte", want.out_byte, got.out_byte);
      cmp_field("byte_present", want.byte_present, got.byte_present);
      cmp_field("run_end", want.run_end, got.run_end);
      cmp_field("text_end", want.text_end, got.text_end);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  in_item_t in_data;
  logic in_stall;
  logic out_valid;
  out_item_t out_data;
  logic out_stall;
  logic cfg_valid;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic cfg_ready;

  ReplaceTracker tracker;
  bit in_rush;
  bit out_rush;
  int hold_left;
  int quiet_cycles;
  int unsigned bytes_sent;
  int unsigned texts_sent;
  int unsigned settings_used;

  stream_substring_replace u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready)
  );

  always #1 clk = ~clk;

  // receiver: after each accepted beat, stall for a random number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (out_valid && !out_stall) begin
      int n;
      n = out_rush ? 0 : $urandom_range(0, 14);
      hold_left <= n;
      out_stall <= (n > 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) tracker.take_byte(in_data);
      if (out_valid && !out_stall) tracker.check_beat(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, bit last);
    int gap;
    gap = in_rush ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, in_last: last};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (last) texts_sent++;
  endtask

  // wait until every pending beat is out, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_config(logic [63:0] pb, logic [3:0] pl, logic [63:0] rb, logic [3:0] rl);
    write_cfg(CFG_PAT_BYTES, pb);
    write_cfg(CFG_PAT_LEN, CFG_W'(pl));
    write_cfg(CFG_REP_BYTES, rb);
    write_cfg(CFG_REP_LEN, CFG_W'(rl));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_phase();
    logic [63:0] pb, rb;
    logic [3:0] pl, rl;
    logic [7:0] a0, a1;
    int unsigned eff, texts, target, kind, cut, pick;
    logic [7:0] text [$];
    a0 = 8'($urandom_range(0, 255));
    a1 = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: pl = 4'd0;
      1: pl = 4'($urandom_range(9, 15));
      default: pl = 4'($urandom_range(1, 8));
    endcase
    eff = (pl == 0) ? 1 : ((pl > 8) ? 8 : pl);
    pb = {$urandom, $urandom};
    // two-letter patterns give self-overlap, so fallbacks get exercised
    if ($urandom_range(0, 2) != 0)
      for (int i = 0; i < 8; i++) pb[8*i +: 8] = $urandom_range(0, 1) ? a1 : a0;
    rl = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    rb = {$urandom, $urandom};
    drain();
    apply_config(pb, pl, rb, rl);
    out_rush = ($urandom_range(0, 3) == 0);
    texts = $urandom_range(2, 4);
    for (int t = 0; t < texts; t++) begin
      text.delete();
      target = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 16);
      while (text.size() < target) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          for (int i = 0; i < eff; i++) text.insert(text.size(), pb[8*i +: 8]);
        end else if (kind < 6) begin
          cut = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
          for (int i = 0; i < cut; i++) text.insert(text.size(), pb[8*i +: 8]);
        end else if (kind < 9) begin
          pick = $urandom_range(0, eff - 1);
          text.insert(text.size(), pb[8*pick +: 8]);
        end else begin
          text.insert(text.size(), 8'($urandom_range(0, 255)));
        end
      end
      while (text.size() > target) void'(text.pop_back());
      in_rush = ($urandom_range(0, 3) == 0);
      foreach (text[j]) send_byte(text[j], j == text.size() - 1);
    end
  endtask

  initial begin
    tracker = new();
    tracker.clear();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PAT_BYTES;
    cfg_data = '0;
    in_rush = 1'b0;
    out_rush = 1'b0;
    bytes_sent = 0;
    texts_sent = 0;
    settings_used = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: one-byte pattern 0x00, deleted
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // "aab" -> "XY": fallback on the third 'a'
    drain();
    apply_config(64'h0000_0000_0062_6161, 4'd3, 64'h0000_0000_0000_5958, 4'd2);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h78, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b1);

    // zero pattern length acts as 1; oversized replacement length clips to 8
    drain();
    apply_config(64'h0000_0000_0000_00FF, 4'd0, 64'h0807_0605_0403_0201, 4'd15);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // oversized pattern length clips to 8; full match deleted on the last byte
    drain();
    apply_config(64'h8877_6655_4433_2211, 4'd15, 64'h0, 4'd0);
    for (int i = 0; i < 8; i++) send_byte(8'((i + 1) * 8'h11), i == 7);

    // pattern rewrite with a partial match held
    drain();
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    drain();
    write_cfg(CFG_PAT_BYTES, 64'h0000_0000_0000_2211);
    write_cfg(CFG_PAT_LEN, CFG_W'(2));
    cfg_valid <= 1'b0;
    send_byte(8'h33, 1'b1);

    while (bytes_sent < 270) random_phase();

    drain();
    $display("sent %0d bytes in %0d texts under %0d register settings",
             bytes_sent, texts_sent, settings_used);
    $display("checked %0d output beats, %0d mismatches",
             tracker.beats_checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/ssr_pkg.sv
src/ssr_front.sv
src/ssr_fifo.sv
src/ssr_back.sv
src/stream_substring_replace.sv
tb/stream_substring_replace_tb.sv
